@@ design/m2i_pkg.sv @@
// Shared constants and types for the 2x2 matrix inverse block.
package m2i_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int EW            = 32;  // element width
  localparam int DW            = 64;  // determinant width
  localparam int QB            = 32;  // quotient bits resolved by the divider
  localparam int RW            = DW + QB + 1;  // divider remainder width
  localparam int QDEPTH        = 4;
  localparam int QAW           = $clog2(QDEPTH);
  localparam int QCW           = $clog2(QDEPTH + 1);
  localparam int NLANE         = 4;

  typedef struct packed {
    logic [EW-1:0] a;
    logic [EW-1:0] b;
    logic [EW-1:0] c;
    logic [EW-1:0] d;
    logic [DW-1:0] dm;       // |det|
    logic          det_neg;
    logic [EW-1:0] det_q;
    logic          det_sat;
    logic          sing;
  } m2i_entry_t;

  typedef struct packed {
    logic [RW-1:0] r;
    logic [QB-1:0] q;
    logic          neg;
    logic          ovf;
  } m2i_lane_t;

endpackage

@@ design/m2i_front.sv @@
// Front end: products, determinant, singular check and determinant output.
module m2i_front import m2i_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [EW-1:0] elem_a,
  input  logic [EW-1:0] elem_b,
  input  logic [EW-1:0] elem_c,
  input  logic [EW-1:0] elem_d,
  output logic          push,
  output m2i_entry_t    entry
);

  localparam logic signed [DW-1:0] MAXV = DW'(64'sd2147483647);
  localparam logic signed [DW-1:0] MINV = -DW'(64'sd2147483648);

  logic                 v1;
  logic [EW-1:0]        a1, b1, c1, d1;
  logic signed [DW-1:0] pad, pbc;
  logic signed [DW-1:0] det, dsh;
  m2i_entry_t           entry_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= take;
    end
  end

  always_ff @(posedge clk) begin
    a1  <= elem_a;
    b1  <= elem_b;
    c1  <= elem_c;
    d1  <= elem_d;
    pad <= $signed(elem_a) * $signed(elem_d);
    pbc <= $signed(elem_b) * $signed(elem_c);
  end

  always_comb begin
    det = pad - pbc;
    dsh = det >>> FRAC_BITS;
    entry_next.a       = a1;
    entry_next.b       = b1;
    entry_next.c       = c1;
    entry_next.d       = d1;
    entry_next.det_neg = det[DW-1];
    entry_next.dm      = det[DW-1] ? DW'(-det) : DW'(det);
    entry_next.sing    = (det == '0);
    if (dsh > MAXV) begin
      entry_next.det_q   = EW'(MAXV);
      entry_next.det_sat = 1'b1;
    end else if (dsh < MINV) begin
      entry_next.det_q   = EW'(MINV);
      entry_next.det_sat = 1'b1;
    end else begin
      entry_next.det_q   = dsh[EW-1:0];
      entry_next.det_sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= v1;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

@@ design/m2i_queue.sv @@
// Short queue between the front end and the divider back end.
module m2i_queue import m2i_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  m2i_entry_t wr_entry,
  output logic       pop,
  output m2i_entry_t rd_entry,
  output logic       almost_full
);

  m2i_entry_t     mem [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QCW-1:0] count;

  // back end never stalls, so drain whenever something is held
  assign pop         = (count != '0);
  assign rd_entry    = mem[rd_ptr];
  assign almost_full = (count >= QCW'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAW'(1);
      if (pop)  rd_ptr <= rd_ptr + QAW'(1);
      count <= count + QCW'(push) - QCW'(pop);
    end
  end

endmodule

@@ design/m2i_back.sv @@
// Back end: pipelined restoring divider for four lanes, saturation, singular handling, result register.
module m2i_back import m2i_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          vin,
  input  m2i_entry_t    entry,
  input  logic          policy,
  output logic          done,
  output logic [EW-1:0] inv_a,
  output logic [EW-1:0] inv_b,
  output logic [EW-1:0] inv_c,
  output logic [EW-1:0] inv_d,
  output logic [EW-1:0] determinant,
  output logic          singular,
  output logic          saturated
);

  localparam logic [QB-1:0] QMAXP = QB'(32'h7FFF_FFFF);
  localparam logic [QB-1:0] QMAXN = QB'(32'h8000_0000);
  localparam logic [EW-1:0] ONE   = EW'(1) << FRAC_BITS;

  function automatic logic [EW-1:0] mag32(input logic [EW-1:0] v);
    return v[EW-1] ? (~v + EW'(1)) : v;
  endfunction

  logic          vld  [QB+1];
  m2i_entry_t    side [QB+1];
  m2i_lane_t     ln   [QB+1][NLANE];

  logic [EW-1:0] nmag [NLANE];
  logic          nneg [NLANE];
  logic [RW-1:0] dmx0;

  always_comb begin
    nmag[0] = mag32(entry.d);
    nneg[0] = entry.d[EW-1];
    nmag[1] = mag32(entry.b);
    nneg[1] = (entry.b != '0) && !entry.b[EW-1];
    nmag[2] = mag32(entry.c);
    nneg[2] = (entry.c != '0) && !entry.c[EW-1];
    nmag[3] = mag32(entry.a);
    nneg[3] = entry.a[EW-1];
    dmx0    = RW'(entry.dm);
  end

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else     vld[0] <= vin;
  end

  always_ff @(posedge clk) begin
    side[0] <= entry;
    for (int j = 0; j < NLANE; j++) begin
      ln[0][j].r   <= RW'(nmag[j]) << (2 * FRAC_BITS);
      ln[0][j].q   <= '0;
      ln[0][j].neg <= nneg[j] ^ entry.det_neg;
      // quotient would need 2^32 or more
      ln[0][j].ovf <= (RW'(nmag[j]) << (2 * FRAC_BITS)) >= (dmx0 << QB);
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_st
    localparam int BI = QB - k;
    logic [RW-1:0] dsh;
    m2i_lane_t     nx [NLANE];
    assign dsh = RW'(side[k-1].dm) << BI;

    always_comb begin
      for (int j = 0; j < NLANE; j++) begin
        nx[j] = ln[k-1][j];
        if (ln[k-1][j].r >= dsh) begin
          nx[j].r     = ln[k-1][j].r - dsh;
          nx[j].q[BI] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vld[k] <= 1'b0;
      else     vld[k] <= vld[k-1];
    end

    always_ff @(posedge clk) begin
      side[k] <= side[k-1];
      for (int j = 0; j < NLANE; j++) begin
        ln[k][j] <= nx[j];
      end
    end
  end

  logic [EW-1:0] val [NLANE];
  logic          lsat [NLANE];
  logic          any_sat;
  m2i_entry_t    fin;

  always_comb begin
    fin     = side[QB];
    any_sat = fin.det_sat;
    for (int j = 0; j < NLANE; j++) begin
      if (!ln[QB][j].neg) begin
        lsat[j] = ln[QB][j].ovf || (ln[QB][j].q > QMAXP);
        val[j]  = lsat[j] ? QMAXP : ln[QB][j].q;
      end else begin
        lsat[j] = ln[QB][j].ovf || (ln[QB][j].q > QMAXN);
        val[j]  = lsat[j] ? QMAXN : (~ln[QB][j].q + EW'(1));
      end
      any_sat = any_sat | lsat[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vld[QB];
  end

  always_ff @(posedge clk) begin
    singular <= fin.sing;
    if (fin.sing) begin
      determinant <= '0;
      saturated   <= 1'b0;
      if (policy) begin
        inv_a <= fin.a;
        inv_b <= fin.b;
        inv_c <= fin.c;
        inv_d <= fin.d;
      end else begin
        inv_a <= ONE;
        inv_b <= '0;
        inv_c <= '0;
        inv_d <= ONE;
      end
    end else begin
      determinant <= fin.det_q;
      saturated   <= any_sat;
      inv_a       <= val[0];
      inv_b       <= val[1];
      inv_c       <= val[2];
      inv_d       <= val[3];
    end
  end

endmodule

@@ design/matrix2x2_inverse.sv @@
// A taken matrix passes front end, queue, divider and result register, then strobes on done.
// Throughput: one matrix per cycle; the 32-stage divider pipeline takes a new beat each cycle.
// The queue between front and back drains every cycle, so busy stays low outside reset.
// The receiver cannot stall; each result is held on the ports for one cycle only.
// Reset (rst, synchronous) clears all valid bits and singular_policy; busy is high in reset.
module matrix2x2_inverse import m2i_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  logic [EW-1:0] elem_a,
  input  logic [EW-1:0] elem_b,
  input  logic [EW-1:0] elem_c,
  input  logic [EW-1:0] elem_d,
  input  logic          cfg_we,
  input  logic          cfg_data,
  output logic          done,
  output logic [EW-1:0] inv_a,
  output logic [EW-1:0] inv_b,
  output logic [EW-1:0] inv_c,
  output logic [EW-1:0] inv_d,
  output logic [EW-1:0] determinant,
  output logic          singular,
  output logic          saturated
);

  logic       singular_policy;
  logic       take;
  logic       push, pop, almost_full;
  m2i_entry_t f_entry, q_entry;

  assign busy = rst | almost_full;
  assign take = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) singular_policy <= 1'b0;
    else if (cfg_we) singular_policy <= cfg_data;
  end

  m2i_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .take,
    .elem_a, .elem_b, .elem_c, .elem_d,
    .push, .entry(f_entry)
  );

  m2i_queue u_queue (
    .clk, .rst, .push, .wr_entry(f_entry),
    .pop, .rd_entry(q_entry), .almost_full
  );

  m2i_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .vin(pop), .entry(q_entry), .policy(singular_policy),
    .done, .inv_a, .inv_b, .inv_c, .inv_d, .determinant, .singular, .saturated
  );

  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    $past(take, QB + 5) |-> done)
    else $error("accepted beat produced no result beat");

  a_latency_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(take, QB + 5))
    else $error("result beat out of step with accepted beat");

  a_sing_clean: assert property (@(posedge clk) disable iff (rst)
    done && singular |-> determinant == '0 && !saturated)
    else $error("singular result carries determinant or saturation");

  a_no_backup: assert property (@(posedge clk) disable iff (rst) !almost_full)
    else $error("queue backed up");

endmodule

@@ tb/matrix2x2_inverse_tb.sv @@
// Testbench for matrix2x2_inverse: directed table plus random matrices, checked by a predictor.
`timescale 1ns / 100ps

module matrix2x2_inverse_tb;
  import m2i_pkg::*;

  localparam int FB        = FRAC_BITS_DEF;
  localparam int N_RANDOM  = 1650;
  localparam int LATENCY   = 37;
  localparam int WDOG_MAX  = 2000;
  localparam logic [EW-1:0] MAXV = 32'h7fff_ffff;
  localparam logic [EW-1:0] MINV = 32'h8000_0000;
  localparam logic [EW-1:0] ONE  = 32'h0001_0000;
  localparam logic POL_IDENT = 1'b0;
  localparam logic POL_KEEP  = 1'b1;

  typedef struct packed {
    logic [EW-1:0] ia, ib, ic, id, det;
    logic          sing, sat;
  } inv_res_t;

  typedef struct {
    logic [EW-1:0] a, b, c, d;
    logic          known;
    inv_res_t      res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [EW-1:0] elem_a = '0, elem_b = '0, elem_c = '0, elem_d = '0;
  logic cfg_we = 1'b0;
  logic cfg_data = 1'b0;
  logic done;
  logic [EW-1:0] inv_a, inv_b, inv_c, inv_d, determinant;
  logic singular, saturated;

  matrix2x2_inverse DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  inv_res_t expected_q[$];
  logic policy;
  int errors = 0;
  int idle_cycles = 0;

  // trunc(num * 2^(2F) / den), saturated to 32 bits
  function automatic logic [EW-1:0] quot_sat(input longint num, input longint den,
                                             inout logic sat);
    logic signed [127:0] n, dd, q;
    n  = num;
    dd = den;
    n  = n <<< (2 * FB);
    q  = n / dd;  // truncates toward zero
    if (q > 128'sd2147483647) begin
      sat = 1'b1;
      return MAXV;
    end
    if (q < -128'sd2147483648) begin
      sat = 1'b1;
      return MINV;
    end
    return q[EW-1:0];
  endfunction

  function automatic inv_res_t predict_inverse(input logic [EW-1:0] a, b, c, d,
                                               input logic pol);
    inv_res_t r;
    longint sa, sb, sc, sd, det, dq;
    logic sat;
    sa = signed'(a); sb = signed'(b); sc = signed'(c); sd = signed'(d);
    det = sa * sd - sb * sc;
    sat = 1'b0;
    r.sing = (det == 0);
    if (r.sing) begin
      if (pol == POL_KEEP) begin
        r.ia = a; r.ib = b; r.ic = c; r.id = d;
      end else begin
        r.ia = ONE; r.ib = '0; r.ic = '0; r.id = ONE;
      end
      r.det = '0;
    end else begin
      r.ia = quot_sat(sd, det, sat);
      r.ib = quot_sat(-sb, det, sat);
      r.ic = quot_sat(-sc, det, sat);
      r.id = quot_sat(sa, det, sat);
      dq = det >>> FB;
      if (dq > 64'sd2147483647) begin
        dq = 64'sd2147483647; sat = 1'b1;
      end else if (dq < -64'sd2147483648) begin
        dq = -64'sd2147483648; sat = 1'b1;
      end
      r.det = dq[EW-1:0];
    end
    r.sat = sat;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    inv_res_t got, exp_r;
    if (!rst && done) begin
      got = '{inv_a, inv_b, inv_c, inv_d, determinant, singular, saturated};
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
        end
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("** matrix2x2_inverse: FAILED **");
      $finish;
    end
  end

  int burst_left = 0;

  // drive one matrix, with bursty random gaps before it
  task automatic send_matrix(input logic [EW-1:0] a, b, c, d, input logic known,
                             input inv_res_t res);
    if (burst_left == 0) begin
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    start <= 1'b1;
    elem_a <= a; elem_b <= b; elem_c <= c; elem_d <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(known ? res : predict_inverse(a, b, c, d, policy));
    burst_left--;
  endtask

  task automatic drain_and_set(input logic pol);
    start <= 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= pol;
    @(posedge clk);
    cfg_we <= 1'b0;
    policy = pol;
  endtask

  function automatic logic [EW-1:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? MAXV : MINV;
      1: return $urandom_range(0, 1) ? ONE : -ONE;
      2: return signed'($urandom_range(0, 600)) - 300;
      3: return ($urandom() & 32'h000f_ffff) - 32'h0008_0000;
      default: return $urandom();
    endcase
  endfunction

  stim_row_t directed[] = '{
    '{ONE, 0, 0, ONE, 1'b1, '{ONE, 0, 0, ONE, ONE, 1'b0, 1'b0}},
    '{0, 0, 0, 0, 1'b1, '{ONE, 0, 0, ONE, 0, 1'b1, 1'b0}},
    '{ONE, ONE, ONE, ONE, 1'b1, '{ONE, 0, 0, ONE, 0, 1'b1, 1'b0}},
    '{MAXV, 0, 0, MAXV, 1'b0, '{default: '0}},
    '{MINV, 0, 0, MINV, 1'b0, '{default: '0}},
    '{MINV, MAXV, MINV, MAXV, 1'b0, '{default: '0}},
    '{MAXV, MINV, MAXV, MAXV, 1'b0, '{default: '0}},
    '{1, 0, 0, 1, 1'b0, '{default: '0}},          // tiny det, quotient clips
    '{32'h100, 0, 0, 32'h100, 1'b0, '{default: '0}}, // det shifts to 1, not singular
    '{0, ONE, -ONE, 0, 1'b0, '{default: '0}},
    '{32'h0002_0000, 32'h0001_8000, 32'hfffe_0000, 32'h0004_0000, 1'b0, '{default: '0}},
    '{-1, 0, 0, -1, 1'b0, '{default: '0}},
    '{32'h0000_ffff, 32'hffff_0000, 32'h0001_0001, 32'h0000_0001, 1'b0, '{default: '0}}
  };

  initial begin
    policy = POL_IDENT;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i])
      send_matrix(directed[i].a, directed[i].b, directed[i].c, directed[i].d,
                  directed[i].known, directed[i].res);
    drain_and_set(POL_KEEP);
    send_matrix(MINV, MAXV, MINV, MAXV, 1'b1, '{MINV, MAXV, MINV, MAXV, 0, 1'b1, 1'b0});
    send_matrix(0, 0, 0, 0, 1'b1, '{0, 0, 0, 0, 0, 1'b1, 1'b0});
    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) drain_and_set(ph[0] ? POL_IDENT : POL_KEEP);
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        logic [EW-1:0] a, b, c, d;
        a = rand_elem(); b = rand_elem(); c = rand_elem(); d = rand_elem();
        // make some singular on purpose: row 1 a copy of row 0, or the right column zero
        if ($urandom_range(0, 7) == 0) begin
          c = a; d = b;
        end else if ($urandom_range(0, 7) == 0) begin
          b = 0; d = 0;
        end
        send_matrix(a, b, c, d, 1'b0, '{default: '0});
      end
    end
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (errors == 0) $display("** matrix2x2_inverse: PASSED **");
    else $display("** matrix2x2_inverse: FAILED **");
    $finish;
  end

endmodule

@@ filelist.f @@
design/m2i_pkg.sv
design/m2i_front.sv
design/m2i_queue.sv
design/m2i_back.sv
design/matrix2x2_inverse.sv
tb/matrix2x2_inverse_tb.sv
